// File: rtl/core/complex_arithmetic_unit_defines.svh
// Assertion helpers shared by the arithmetic unit.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

`define CAU_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define CAU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  `CAU_ASSERT(label, clk, rst, (ante) |-> (cons), msg)

`endif

// File: rtl/core/cau_pkg.sv
package cau_pkg;

  localparam int DATA_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF = 8;
  localparam int MODE_W = 3;

  localparam logic [MODE_W-1:0] MODE_ADD = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SUB = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MUL = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DIV = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MOD = 3'd4;

  typedef struct packed {
    logic              valid;
    logic [MODE_W-1:0] mode;
  } cau_ctrl_t;

endpackage

// File: rtl/core/complex_arithmetic_unit.sv
// Complex-number ALU in signed fixed point (Q8.8 by default): add, subtract,
// multiply, divide, or the modulus of a. An item is taken whenever start is
// high; busy never rises, so one item can enter in every cycle. Each result
// appears on done in order, for a single cycle; the receiver cannot stall it
// and must take every beat as it comes. An item passes three stages of
// multiply and combine logic, then a row of DATA_BITS+2 cells, each producing
// one quotient bit of the divider (the lower DATA_BITS cells also produce one
// bit of the square root), and then one output register.
`include "complex_arithmetic_unit_defines.svh"

module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int DATA_BITS = DATA_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [MODE_W-1:0]           mode,
  input  logic signed [DATA_BITS-1:0] a_real,
  input  logic signed [DATA_BITS-1:0] a_imag,
  input  logic signed [DATA_BITS-1:0] b_real,
  input  logic signed [DATA_BITS-1:0] b_imag,
  output logic                        done,
  output logic signed [DATA_BITS-1:0] res_real,
  output logic signed [DATA_BITS-1:0] res_imag,
  output logic                        overflow,
  output logic                        div_zero
);

  localparam int D   = DATA_BITS;
  localparam int RW  = 3 * DATA_BITS + FRAC_BITS + 2;
  localparam int PW  = 2 * DATA_BITS;
  localparam int K   = DATA_BITS + 2;
  localparam int LAT = K + 4;

  assign busy = 1'b0;

  cau_ctrl_t     ctrl   [0:K];
  logic [D-1:0]  fin_re [0:K];
  logic [D-1:0]  fin_im [0:K];
  logic          fin_ovf[0:K];
  logic          fin_dz [0:K];
  logic          neg_r  [0:K];
  logic          neg_i  [0:K];
  logic          sat_r  [0:K];
  logic          sat_i  [0:K];
  logic [RW-1:0] rem_r  [0:K];
  logic [RW-1:0] rem_i  [0:K];
  logic [K-1:0]  q_r    [0:K];
  logic [K-1:0]  q_i    [0:K];
  logic [PW-1:0] den    [0:K];
  logic [PW-1:0] sq_rem [0:K];
  logic [D-1:0]  root   [0:K];

  cau_front #(
    .DATA_BITS(DATA_BITS), .FRAC_BITS(FRAC_BITS), .RW(RW), .PW(PW), .K(K)
  ) u_front (
    .clk, .rst, .start, .mode, .a_real, .a_imag, .b_real, .b_imag,
    .dst_ctrl(ctrl[0]), .dst_fin_re(fin_re[0]), .dst_fin_im(fin_im[0]),
    .dst_fin_ovf(fin_ovf[0]), .dst_fin_dz(fin_dz[0]),
    .dst_neg_r(neg_r[0]), .dst_neg_i(neg_i[0]),
    .dst_sat_r(sat_r[0]), .dst_sat_i(sat_i[0]),
    .dst_rem_r(rem_r[0]), .dst_rem_i(rem_i[0]),
    .dst_q_r(q_r[0]), .dst_q_i(q_i[0]), .dst_den(den[0]),
    .dst_sq_rem(sq_rem[0]), .dst_root(root[0])
  );

  // Cell c resolves bit K-1-c, so the most significant bit is settled first.
  for (genvar c = 0; c < K; c++) begin : g_cell
    cau_cell #(
      .DATA_BITS(DATA_BITS), .RW(RW), .PW(PW), .K(K), .J(K - 1 - c)
    ) u_cell (
      .clk, .rst,
      .src_ctrl(ctrl[c]), .src_fin_re(fin_re[c]), .src_fin_im(fin_im[c]),
      .src_fin_ovf(fin_ovf[c]), .src_fin_dz(fin_dz[c]),
      .src_neg_r(neg_r[c]), .src_neg_i(neg_i[c]),
      .src_sat_r(sat_r[c]), .src_sat_i(sat_i[c]),
      .src_rem_r(rem_r[c]), .src_rem_i(rem_i[c]),
      .src_q_r(q_r[c]), .src_q_i(q_i[c]), .src_den(den[c]),
      .src_sq_rem(sq_rem[c]), .src_root(root[c]),
      .dst_ctrl(ctrl[c+1]), .dst_fin_re(fin_re[c+1]), .dst_fin_im(fin_im[c+1]),
      .dst_fin_ovf(fin_ovf[c+1]), .dst_fin_dz(fin_dz[c+1]),
      .dst_neg_r(neg_r[c+1]), .dst_neg_i(neg_i[c+1]),
      .dst_sat_r(sat_r[c+1]), .dst_sat_i(sat_i[c+1]),
      .dst_rem_r(rem_r[c+1]), .dst_rem_i(rem_i[c+1]),
      .dst_q_r(q_r[c+1]), .dst_q_i(q_i[c+1]), .dst_den(den[c+1]),
      .dst_sq_rem(sq_rem[c+1]), .dst_root(root[c+1])
    );
  end

  cau_back #(
    .DATA_BITS(DATA_BITS), .RW(RW), .PW(PW), .K(K)
  ) u_back (
    .clk, .rst,
    .src_ctrl(ctrl[K]), .src_fin_re(fin_re[K]), .src_fin_im(fin_im[K]),
    .src_fin_ovf(fin_ovf[K]), .src_fin_dz(fin_dz[K]),
    .src_neg_r(neg_r[K]), .src_neg_i(neg_i[K]),
    .src_sat_r(sat_r[K]), .src_sat_i(sat_i[K]),
    .src_q_r(q_r[K]), .src_q_i(q_i[K]),
    .src_sq_rem(sq_rem[K]), .src_root(root[K]),
    .done, .res_real, .res_imag, .overflow, .div_zero
  );

  // Every start beat comes out as a result beat on done.
  `CAU_ASSERT_IMP(a_latency, clk, rst, start, ##LAT done, "result beat missing after latency")
  `CAU_ASSERT_IMP(a_dz_clean, clk, rst, done && div_zero, !overflow, "zero divisor raised overflow")
  `CAU_ASSERT_IMP(a_dz_zero, clk, rst, done && div_zero, res_real == '0 && res_imag == '0,
    "zero divisor gave a non-zero result")

endmodule

// File: rtl/core/cau_front.sv
module cau_front import cau_pkg::*; #(
  parameter int DATA_BITS = DATA_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int RW = 3 * DATA_BITS + FRAC_BITS + 2,
  parameter int PW = 2 * DATA_BITS,
  parameter int K  = DATA_BITS + 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [MODE_W-1:0]           mode,
  input  logic signed [DATA_BITS-1:0] a_real,
  input  logic signed [DATA_BITS-1:0] a_imag,
  input  logic signed [DATA_BITS-1:0] b_real,
  input  logic signed [DATA_BITS-1:0] b_imag,
  output cau_ctrl_t                   dst_ctrl,
  output logic [DATA_BITS-1:0]        dst_fin_re,
  output logic [DATA_BITS-1:0]        dst_fin_im,
  output logic                        dst_fin_ovf,
  output logic                        dst_fin_dz,
  output logic                        dst_neg_r,
  output logic                        dst_neg_i,
  output logic                        dst_sat_r,
  output logic                        dst_sat_i,
  output logic [RW-1:0]               dst_rem_r,
  output logic [RW-1:0]               dst_rem_i,
  output logic [K-1:0]                dst_q_r,
  output logic [K-1:0]                dst_q_i,
  output logic [PW-1:0]               dst_den,
  output logic [PW-1:0]               dst_sq_rem,
  output logic [DATA_BITS-1:0]        dst_root
);

  localparam int D = DATA_BITS;
  localparam logic [RW-1:0] NEG_MAG = RW'(1) << (D - 1);
  localparam logic [RW-1:0] POS_MAX = NEG_MAG - RW'(1);
  localparam logic [PW:0] HALF = ((PW + 1)'(1) << FRAC_BITS) >> 1;

  function automatic logic [D:0] sat(input logic neg, input logic [RW-1:0] mag);
    logic [D:0] r;
    if (neg) begin
      if (mag > NEG_MAG) r = {1'b1, NEG_MAG[D-1:0]};
      else               r = {1'b0, D'(RW'(0) - mag)};
    end else begin
      if (mag > POS_MAX) r = {1'b1, POS_MAX[D-1:0]};
      else               r = {1'b0, mag[D-1:0]};
    end
    return r;
  endfunction

  // Stage A: products and the exact sum or difference.
  cau_ctrl_t           a_ctrl;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, sq_r, sq_i, d_r, d_i;
  logic [D:0]          s_re, s_im;

  always_ff @(posedge clk) begin
    if (rst) a_ctrl.valid <= 1'b0;
    else     a_ctrl.valid <= start;
    a_ctrl.mode <= mode;
    p_rr <= PW'(a_real) * PW'(b_real);
    p_ii <= PW'(a_imag) * PW'(b_imag);
    p_ri <= PW'(a_real) * PW'(b_imag);
    p_ir <= PW'(a_imag) * PW'(b_real);
    sq_r <= PW'(a_real) * PW'(a_real);
    sq_i <= PW'(a_imag) * PW'(a_imag);
    d_r  <= PW'(b_real) * PW'(b_real);
    d_i  <= PW'(b_imag) * PW'(b_imag);
    if (mode == MODE_SUB) begin
      s_re <= {a_real[D-1], a_real} - {b_real[D-1], b_real};
      s_im <= {a_imag[D-1], a_imag} - {b_imag[D-1], b_imag};
    end else begin
      s_re <= {a_real[D-1], a_real} + {b_real[D-1], b_real};
      s_im <= {a_imag[D-1], a_imag} + {b_imag[D-1], b_imag};
    end
  end

  // Stage B: combine products, split into sign and magnitude, saturate the sum or difference.
  logic [PW:0] num_re, num_im, neg_re_v, neg_im_v;
  logic [D-1:0] as_re, as_im;
  logic         as_ovf;

  always_comb begin
    if (a_ctrl.mode == MODE_MUL) begin
      num_re = {p_rr[PW-1], p_rr} - {p_ii[PW-1], p_ii};
      num_im = {p_ri[PW-1], p_ri} + {p_ir[PW-1], p_ir};
    end else begin
      num_re = {p_rr[PW-1], p_rr} + {p_ii[PW-1], p_ii};
      num_im = {p_ir[PW-1], p_ir} - {p_ri[PW-1], p_ri};
    end
    neg_re_v = (PW + 1)'(0) - num_re;
    neg_im_v = (PW + 1)'(0) - num_im;
    as_ovf = (s_re[D] != s_re[D-1]) || (s_im[D] != s_im[D-1]);
    if (s_re[D] != s_re[D-1]) as_re = s_re[D] ? NEG_MAG[D-1:0] : POS_MAX[D-1:0];
    else                      as_re = s_re[D-1:0];
    if (s_im[D] != s_im[D-1]) as_im = s_im[D] ? NEG_MAG[D-1:0] : POS_MAX[D-1:0];
    else                      as_im = s_im[D-1:0];
  end

  cau_ctrl_t   b_ctrl;
  logic        b_neg_re, b_neg_im, b_ovf;
  logic [PW-1:0] b_mag_re, b_mag_im, b_den, b_sq;
  logic [D-1:0] b_re, b_im;

  always_ff @(posedge clk) begin
    if (rst) b_ctrl.valid <= 1'b0;
    else     b_ctrl.valid <= a_ctrl.valid;
    b_ctrl.mode <= a_ctrl.mode;
    b_neg_re <= num_re[PW];
    b_neg_im <= num_im[PW];
    b_mag_re <= num_re[PW] ? neg_re_v[PW-1:0] : num_re[PW-1:0];
    b_mag_im <= num_im[PW] ? neg_im_v[PW-1:0] : num_im[PW-1:0];
    b_den <= PW'(d_r) + PW'(d_i);
    b_sq  <= PW'(sq_r) + PW'(sq_i);
    b_re  <= as_re;
    b_im  <= as_im;
    b_ovf <= as_ovf;
  end

  // Stage C: round products, check the quotient range, seed the divider.
  logic [PW:0]   rm_re, rm_im;
  logic [D:0]    ms_re, ms_im;
  logic [RW-1:0] n_re, n_im, lim;
  logic [D-1:0]  f_re, f_im;
  logic          f_ovf, f_dz;

  always_comb begin
    rm_re = ({1'b0, b_mag_re} + HALF) >> FRAC_BITS;
    rm_im = ({1'b0, b_mag_im} + HALF) >> FRAC_BITS;
    ms_re = sat(b_neg_re, RW'(rm_re));
    ms_im = sat(b_neg_im, RW'(rm_im));
    n_re = RW'(b_mag_re) << (FRAC_BITS + 1);
    n_im = RW'(b_mag_im) << (FRAC_BITS + 1);
    lim  = RW'(b_den) << K;
    f_re = '0;
    f_im = '0;
    f_ovf = 1'b0;
    f_dz = 1'b0;
    unique case (b_ctrl.mode)
      MODE_ADD, MODE_SUB: begin
        f_re = b_re;
        f_im = b_im;
        f_ovf = b_ovf;
      end
      MODE_MUL: begin
        f_re = ms_re[D-1:0];
        f_im = ms_im[D-1:0];
        f_ovf = ms_re[D] | ms_im[D];
      end
      MODE_DIV: f_dz = (b_den == '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) dst_ctrl.valid <= 1'b0;
    else     dst_ctrl.valid <= b_ctrl.valid;
    dst_ctrl.mode <= b_ctrl.mode;
    dst_fin_re  <= f_re;
    dst_fin_im  <= f_im;
    dst_fin_ovf <= f_ovf;
    dst_fin_dz  <= f_dz;
    dst_neg_r   <= b_neg_re;
    dst_neg_i   <= b_neg_im;
    dst_sat_r   <= n_re >= lim;
    dst_sat_i   <= n_im >= lim;
    dst_rem_r   <= n_re;
    dst_rem_i   <= n_im;
    dst_q_r     <= '0;
    dst_q_i     <= '0;
    dst_den     <= b_den;
    dst_sq_rem  <= b_sq;
    dst_root    <= '0;
  end

endmodule

// File: rtl/core/cau_cell.sv
module cau_cell import cau_pkg::*; #(
  parameter int DATA_BITS = DATA_BITS_DEF,
  parameter int RW = 3 * DATA_BITS + FRAC_BITS_DEF + 2,
  parameter int PW = 2 * DATA_BITS,
  parameter int K  = DATA_BITS + 2,
  parameter int J  = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cau_ctrl_t            src_ctrl,
  input  logic [DATA_BITS-1:0] src_fin_re,
  input  logic [DATA_BITS-1:0] src_fin_im,
  input  logic                 src_fin_ovf,
  input  logic                 src_fin_dz,
  input  logic                 src_neg_r,
  input  logic                 src_neg_i,
  input  logic                 src_sat_r,
  input  logic                 src_sat_i,
  input  logic [RW-1:0]        src_rem_r,
  input  logic [RW-1:0]        src_rem_i,
  input  logic [K-1:0]         src_q_r,
  input  logic [K-1:0]         src_q_i,
  input  logic [PW-1:0]        src_den,
  input  logic [PW-1:0]        src_sq_rem,
  input  logic [DATA_BITS-1:0] src_root,
  output cau_ctrl_t            dst_ctrl,
  output logic [DATA_BITS-1:0] dst_fin_re,
  output logic [DATA_BITS-1:0] dst_fin_im,
  output logic                 dst_fin_ovf,
  output logic                 dst_fin_dz,
  output logic                 dst_neg_r,
  output logic                 dst_neg_i,
  output logic                 dst_sat_r,
  output logic                 dst_sat_i,
  output logic [RW-1:0]        dst_rem_r,
  output logic [RW-1:0]        dst_rem_i,
  output logic [K-1:0]         dst_q_r,
  output logic [K-1:0]         dst_q_i,
  output logic [PW-1:0]        dst_den,
  output logic [PW-1:0]        dst_sq_rem,
  output logic [DATA_BITS-1:0] dst_root
);

  localparam int D = DATA_BITS;

  logic [RW-1:0] trial;
  logic          take_r, take_i, take_s;
  logic [PW:0]   t_sq;

  // One quotient bit for both parts; the lower cells also settle one root bit.
  always_comb begin
    trial  = RW'(src_den) << J;
    take_r = src_rem_r >= trial;
    take_i = src_rem_i >= trial;
    t_sq   = '0;
    take_s = 1'b0;
    if (J < D) begin
      t_sq   = ((PW + 1)'(src_root) << (J + 1)) + ((PW + 1)'(1) << (2 * J));
      take_s = {1'b0, src_sq_rem} >= t_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dst_ctrl.valid <= 1'b0;
    else     dst_ctrl.valid <= src_ctrl.valid;
    dst_ctrl.mode <= src_ctrl.mode;
    dst_fin_re  <= src_fin_re;
    dst_fin_im  <= src_fin_im;
    dst_fin_ovf <= src_fin_ovf;
    dst_fin_dz  <= src_fin_dz;
    dst_neg_r   <= src_neg_r;
    dst_neg_i   <= src_neg_i;
    dst_sat_r   <= src_sat_r;
    dst_sat_i   <= src_sat_i;
    dst_rem_r   <= take_r ? src_rem_r - trial : src_rem_r;
    dst_rem_i   <= take_i ? src_rem_i - trial : src_rem_i;
    dst_q_r     <= src_q_r | (K'(take_r) << J);
    dst_q_i     <= src_q_i | (K'(take_i) << J);
    dst_den     <= src_den;
    dst_sq_rem  <= take_s ? src_sq_rem - t_sq[PW-1:0] : src_sq_rem;
    dst_root    <= src_root | (D'(take_s) << J);
  end

endmodule

// File: rtl/core/cau_back.sv
module cau_back import cau_pkg::*; #(
  parameter int DATA_BITS = DATA_BITS_DEF,
  parameter int RW = 3 * DATA_BITS + FRAC_BITS_DEF + 2,
  parameter int PW = 2 * DATA_BITS,
  parameter int K  = DATA_BITS + 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cau_ctrl_t                    src_ctrl,
  input  logic [DATA_BITS-1:0]         src_fin_re,
  input  logic [DATA_BITS-1:0]         src_fin_im,
  input  logic                         src_fin_ovf,
  input  logic                         src_fin_dz,
  input  logic                         src_neg_r,
  input  logic                         src_neg_i,
  input  logic                         src_sat_r,
  input  logic                         src_sat_i,
  input  logic [K-1:0]                 src_q_r,
  input  logic [K-1:0]                 src_q_i,
  input  logic [PW-1:0]                src_sq_rem,
  input  logic [DATA_BITS-1:0]         src_root,
  output logic                         done,
  output logic signed [DATA_BITS-1:0]  res_real,
  output logic signed [DATA_BITS-1:0]  res_imag,
  output logic                         overflow,
  output logic                         div_zero
);

  localparam int D = DATA_BITS;
  localparam logic [RW-1:0] NEG_MAG = RW'(1) << (D - 1);
  localparam logic [RW-1:0] POS_MAX = NEG_MAG - RW'(1);
  localparam logic [RW-1:0] BIG = RW'(1) << D;

  function automatic logic [D:0] sat(input logic neg, input logic [RW-1:0] mag);
    logic [D:0] r;
    if (neg) begin
      if (mag > NEG_MAG) r = {1'b1, NEG_MAG[D-1:0]};
      else               r = {1'b0, D'(RW'(0) - mag)};
    end else begin
      if (mag > POS_MAX) r = {1'b1, POS_MAX[D-1:0]};
      else               r = {1'b0, mag[D-1:0]};
    end
    return r;
  endfunction

  logic [K:0]   qm_r, qm_i;
  logic [D:0]   dv_r, dv_i, sq, root_rnd;
  logic [D-1:0] o_re, o_im;
  logic         o_ovf;

  always_comb begin
    // The quotient carries one extra fraction bit for rounding.
    qm_r = ({1'b0, src_q_r} + (K + 1)'(1)) >> 1;
    qm_i = ({1'b0, src_q_i} + (K + 1)'(1)) >> 1;
    dv_r = sat(src_neg_r, src_sat_r ? BIG : RW'(qm_r));
    dv_i = sat(src_neg_i, src_sat_i ? BIG : RW'(qm_i));
    root_rnd = {1'b0, src_root} + (D + 1)'(src_sq_rem > PW'(src_root));
    sq = sat(1'b0, RW'(root_rnd));
    if (src_ctrl.mode == MODE_DIV && !src_fin_dz) begin
      o_re = dv_r[D-1:0];
      o_im = dv_i[D-1:0];
      o_ovf = dv_r[D] | dv_i[D];
    end else if (src_ctrl.mode == MODE_MOD) begin
      o_re = sq[D-1:0];
      o_im = '0;
      o_ovf = sq[D];
    end else begin
      o_re = src_fin_re;
      o_im = src_fin_im;
      o_ovf = src_fin_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= src_ctrl.valid;
    res_real <= o_re;
    res_imag <= o_im;
    overflow <= o_ovf;
    div_zero <= src_fin_dz;
  end

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  import cau_pkg::*;

  localparam int DW = 16;
  localparam int FW = 8;
  localparam int LATENCY = DW + 6;

  typedef struct packed {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
    logic                 ovf;
    logic                 dz;
  } cplx_res_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [MODE_W-1:0]    mode;
  logic signed [DW-1:0] a_real;
  logic signed [DW-1:0] a_imag;
  logic signed [DW-1:0] b_real;
  logic signed [DW-1:0] b_imag;
  logic                 done;
  logic signed [DW-1:0] res_real;
  logic signed [DW-1:0] res_imag;
  logic                 overflow;
  logic                 div_zero;

  cplx_res_t pending_results[$];
  int        fail_count;
  int        beats_sent;
  int        results_seen;
  int        send_idle_pct;
  int        mode_count[8];

  complex_arithmetic_unit #(.DATA_BITS(DW), .FRAC_BITS(FW)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .a_real(a_real), .a_imag(a_imag), .b_real(b_real), .b_imag(b_imag),
    .done(done), .res_real(res_real), .res_imag(res_imag),
    .overflow(overflow), .div_zero(div_zero)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Clamp a wide signed value to the output range, noting any saturation.
  function automatic logic signed [DW-1:0] clamp_part(input logic signed [71:0] v,
                                                      inout logic ovf);
    logic signed [71:0] hi;
    logic signed [71:0] lo;
    hi = (72'sd1 <<< (DW - 1)) - 1;
    lo = -(72'sd1 <<< (DW - 1));
    if (v > hi) begin
      ovf = 1'b1;
      return hi[DW-1:0];
    end
    if (v < lo) begin
      ovf = 1'b1;
      return lo[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  // Drop FW fraction bits, rounding to nearest with ties away from zero.
  function automatic logic signed [71:0] round_frac(input logic signed [71:0] v);
    logic [71:0] m;
    m = (v < 0) ? -v : v;
    m = (m + (72'd1 << (FW - 1))) >> FW;
    return (v < 0) ? -$signed(m) : $signed(m);
  endfunction

  // Quotient num * 2^FW / den, rounded to nearest with ties away from zero.
  function automatic logic signed [71:0] scaled_quot(input logic signed [71:0] num,
                                                     input logic [71:0] den);
    logic [71:0] m;
    logic [71:0] q;
    m = (num < 0) ? -num : num;
    q = ((m << (FW + 1)) / den + 1) >> 1;
    return (num < 0) ? -$signed(q) : $signed(q);
  endfunction

  function automatic cplx_res_t complex_op(input logic [MODE_W-1:0] op,
                                           input logic signed [DW-1:0] ar,
                                           input logic signed [DW-1:0] ai,
                                           input logic signed [DW-1:0] br,
                                           input logic signed [DW-1:0] bi);
    cplx_res_t r;
    logic signed [71:0] xr;
    logic signed [71:0] xi;
    logic signed [71:0] yr;
    logic signed [71:0] yi;
    logic [71:0] den;
    logic [71:0] sq;
    logic [71:0] root;
    logic o;
    xr = 72'(ar);
    xi = 72'(ai);
    yr = 72'(br);
    yi = 72'(bi);
    o = 1'b0;
    r = '0;
    case (op)
      MODE_ADD: begin
        r.re = clamp_part(xr + yr, o);
        r.im = clamp_part(xi + yi, o);
      end
      MODE_SUB: begin
        r.re = clamp_part(xr - yr, o);
        r.im = clamp_part(xi - yi, o);
      end
      MODE_MUL: begin
        r.re = clamp_part(round_frac(xr * yr - xi * yi), o);
        r.im = clamp_part(round_frac(xr * yi + xi * yr), o);
      end
      MODE_DIV: begin
        den = yr * yr + yi * yi;
        if (den == 0) r.dz = 1'b1;
        else begin
          r.re = clamp_part(scaled_quot(xr * yr + xi * yi, den), o);
          r.im = clamp_part(scaled_quot(xi * yr - xr * yi, den), o);
        end
      end
      MODE_MOD: begin
        sq = xr * xr + xi * xi;
        root = 0;
        for (int b = 17; b >= 0; b--) begin
          if ((root | (72'd1 << b)) * (root | (72'd1 << b)) <= sq) root |= 72'd1 << b;
        end
        if (sq - root * root > root) root++;
        r.re = clamp_part($signed(root), o);
      end
      default: ;
    endcase
    r.ovf = o;
    return r;
  endfunction

  // One beat: an optional random gap, then hold start until the block takes it.
  task automatic send_item(input logic [MODE_W-1:0] op, input logic signed [DW-1:0] ar,
                           input logic signed [DW-1:0] ai, input logic signed [DW-1:0] br,
                           input logic signed [DW-1:0] bi);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    mode   <= op;
    a_real <= ar;
    a_imag <= ai;
    b_real <= br;
    b_imag <= bi;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(complex_op(op, ar, ai, br, bi));
    beats_sent++;
    mode_count[op]++;
  endtask

  task automatic go_idle();
    start <= 1'b0;
  endtask

  function automatic logic signed [DW-1:0] rand_operand();
    case ($urandom_range(5))
      0: return DW'(16'sh7fff - $urandom_range(3));
      1: return DW'(-16'sh8000 + $urandom_range(3));
      2: return DW'($urandom_range(15) - 8);
      3: return DW'($urandom_range(1023) - 512);
      default: return DW'($urandom);
    endcase
  endfunction

  task automatic test_extremes();
    logic signed [DW-1:0] vals[6];
    vals = '{16'sh7fff, -16'sh8000, 16'sh0000, 16'sh0100, -16'sh0100, 16'sh0001};
    for (int op = 0; op < 8; op++) begin
      send_item(MODE_W'(op), vals[op % 6], vals[(op + 1) % 6], vals[(op + 2) % 6],
                vals[(op + 3) % 6]);
    end
    send_item(MODE_DIV, 16'sh0100, 16'sh0100, 16'sh0000, 16'sh0000);
    send_item(MODE_DIV, 16'sh7fff, 16'sh7fff, 16'sh0001, 16'sh0000);
    send_item(MODE_DIV, -16'sh8000, -16'sh8000, 16'sh0000, -16'sh0001);
    send_item(MODE_DIV, 16'sh0003, 16'sh0000, 16'sh0002, 16'sh0000);
    send_item(MODE_MUL, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
    send_item(MODE_MUL, 16'sh0080, 16'sh0000, 16'sh0001, 16'sh0000);
    send_item(MODE_MUL, -16'sh0080, 16'sh0000, 16'sh0001, 16'sh0000);
    send_item(MODE_MOD, -16'sh8000, -16'sh8000, 16'sh0000, 16'sh0000);
    send_item(MODE_MOD, 16'sh0003, 16'sh0004, 16'sh0000, 16'sh0000);
    send_item(MODE_MOD, 16'sh0000, 16'sh0000, 16'sh7fff, 16'sh7fff);
    send_item(MODE_ADD, 16'sh7fff, -16'sh8000, 16'sh0001, -16'sh0001);
    send_item(MODE_SUB, -16'sh8000, 16'sh7fff, 16'sh0001, -16'sh0001);
    go_idle();
  endtask

  task automatic test_random(input int count, input int idle_pct);
    logic [MODE_W-1:0] op;
    send_idle_pct = idle_pct;
    for (int n = 0; n < count; n++) begin
      op = ($urandom_range(19) == 0) ? MODE_W'($urandom_range(7, 5))
                                     : MODE_W'($urandom_range(4));
      if (op == MODE_DIV && $urandom_range(9) == 0)
        send_item(op, rand_operand(), rand_operand(), '0, '0);
      else
        send_item(op, rand_operand(), rand_operand(), rand_operand(), rand_operand());
    end
    go_idle();
  endtask

  // Results cannot be stalled, so every done beat is checked as it passes.
  always @(posedge clk) begin
    cplx_res_t want;
    if (!rst && done) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %h %h %b %b", $time,
                 res_real, res_imag, overflow, div_zero);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (res_real !== want.re || res_imag !== want.im ||
            overflow !== want.ovf || div_zero !== want.dz) begin
          $display("%0t: mismatch, expected %h %h ovf=%b dz=%b, got %h %h ovf=%b dz=%b",
                   $time, want.re, want.im, want.ovf, want.dz,
                   res_real, res_imag, overflow, div_zero);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int guard;
    rst = 1'b1;
    start = 1'b0;
    mode = '0;
    a_real = '0;
    a_imag = '0;
    b_real = '0;
    b_imag = '0;
    fail_count = 0;
    beats_sent = 0;
    results_seen = 0;
    send_idle_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_random(480, 26);
    test_random(480, 85);
    test_random(480, 0);
    guard = 0;
    while (pending_results.size() != 0 && guard < 10 * LATENCY) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      fail_count++;
    end
    $display("Sent %0d beats (add %0d sub %0d mul %0d div %0d mod %0d unused %0d).",
             beats_sent, mode_count[0], mode_count[1], mode_count[2], mode_count[3],
             mode_count[4], mode_count[5] + mode_count[6] + mode_count[7]);
    $display("Checked %0d result beats, %0d failures.", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
